>>> rtl/core/rapp_pkg.sv
// Shared types, constants and the sine table for the rotate and project core.
package rapp_pkg;

  localparam int COORD_WIDTH_DEF    = 24;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int DIST_WIDTH         = 23;
  localparam logic [DIST_WIDTH-1:0] DIST_RESET = 23'd7680;
  localparam int FIFO_DEPTH         = 4;

  typedef enum logic [1:0] {
    OP_ROT_X = 2'd0,
    OP_ROT_Y = 2'd1,
    OP_ROT_Z = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  // Quarter-wave sine scaled by 65536, rounded.
  function automatic logic [16:0] quarter_sine(input logic [6:0] k);
    logic [16:0] v;
    case (k)
      7'd0: v = 17'd0;      7'd1: v = 17'd1144;   7'd2: v = 17'd2287;
      7'd3: v = 17'd3430;   7'd4: v = 17'd4572;   7'd5: v = 17'd5712;
      7'd6: v = 17'd6850;   7'd7: v = 17'd7987;   7'd8: v = 17'd9121;
      7'd9: v = 17'd10252;  7'd10: v = 17'd11380; 7'd11: v = 17'd12505;
      7'd12: v = 17'd13626; 7'd13: v = 17'd14742; 7'd14: v = 17'd15855;
      7'd15: v = 17'd16962; 7'd16: v = 17'd18064; 7'd17: v = 17'd19161;
      7'd18: v = 17'd20252; 7'd19: v = 17'd21336; 7'd20: v = 17'd22415;
      7'd21: v = 17'd23486; 7'd22: v = 17'd24550; 7'd23: v = 17'd25607;
      7'd24: v = 17'd26656; 7'd25: v = 17'd27697; 7'd26: v = 17'd28729;
      7'd27: v = 17'd29753; 7'd28: v = 17'd30767; 7'd29: v = 17'd31772;
      7'd30: v = 17'd32768; 7'd31: v = 17'd33754; 7'd32: v = 17'd34729;
      7'd33: v = 17'd35693; 7'd34: v = 17'd36647; 7'd35: v = 17'd37590;
      7'd36: v = 17'd38521; 7'd37: v = 17'd39441; 7'd38: v = 17'd40348;
      7'd39: v = 17'd41243; 7'd40: v = 17'd42126; 7'd41: v = 17'd42995;
      7'd42: v = 17'd43852; 7'd43: v = 17'd44695; 7'd44: v = 17'd45525;
      7'd45: v = 17'd46341; 7'd46: v = 17'd47143; 7'd47: v = 17'd47930;
      7'd48: v = 17'd48703; 7'd49: v = 17'd49461; 7'd50: v = 17'd50204;
      7'd51: v = 17'd50931; 7'd52: v = 17'd51643; 7'd53: v = 17'd52339;
      7'd54: v = 17'd53020; 7'd55: v = 17'd53684; 7'd56: v = 17'd54332;
      7'd57: v = 17'd54963; 7'd58: v = 17'd55578; 7'd59: v = 17'd56175;
      7'd60: v = 17'd56756; 7'd61: v = 17'd57319; 7'd62: v = 17'd57865;
      7'd63: v = 17'd58393; 7'd64: v = 17'd58903; 7'd65: v = 17'd59396;
      7'd66: v = 17'd59870; 7'd67: v = 17'd60326; 7'd68: v = 17'd60764;
      7'd69: v = 17'd61183; 7'd70: v = 17'd61584; 7'd71: v = 17'd61966;
      7'd72: v = 17'd62328; 7'd73: v = 17'd62672; 7'd74: v = 17'd62997;
      7'd75: v = 17'd63303; 7'd76: v = 17'd63589; 7'd77: v = 17'd63856;
      7'd78: v = 17'd64104; 7'd79: v = 17'd64332; 7'd80: v = 17'd64540;
      7'd81: v = 17'd64729; 7'd82: v = 17'd64898; 7'd83: v = 17'd65048;
      7'd84: v = 17'd65177; 7'd85: v = 17'd65287; 7'd86: v = 17'd65376;
      7'd87: v = 17'd65446; 7'd88: v = 17'd65496; 7'd89: v = 17'd65526;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/rapp_front.sv
// Front end: angle reduction, sine and cosine lookup, rotation and rounding.
module rapp_front #(
  parameter int CW = rapp_pkg::COORD_WIDTH_DEF,
  parameter int TF = rapp_pkg::TRIG_FRAC_BITS_DEF,
  parameter int RW = CW + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] z_in,
  input  logic [1:0]           op_in,
  input  logic [8:0]           angle_in,
  input  logic                 last_in,
  output logic                 out_valid,
  output logic signed [RW-1:0] rx_out,
  output logic signed [RW-1:0] ry_out,
  output logic signed [RW-1:0] rz_out,
  output logic                 last_out
);
  localparam int TW = TF + 2;
  localparam int PW = CW + TW;

  // Stage 1: trig lookup.
  logic                 v1_r;
  logic signed [CW-1:0] x1_r, y1_r, z1_r;
  logic [1:0]           op1_r;
  logic                 l1_r;
  logic signed [TW-1:0] s1_r, c1_r;
  // Stage 2: products.
  logic                 v2_r;
  logic [1:0]           op2_r;
  logic                 l2_r;
  logic signed [CW-1:0] x2_r, y2_r, z2_r;
  logic signed [PW-1:0] pxc_r, pxs_r, pyc_r, pys_r, pzc_r, pzs_r;
  // Stage 3: rotated coordinates.
  logic                 v3_r;
  logic signed [RW-1:0] rx3_r, ry3_r, rz3_r;
  logic                 l3_r;

  function automatic logic signed [TW-1:0] trig_entry(input logic [6:0] k);
    logic [17:0] t;
    t = ({1'b0, rapp_pkg::quarter_sine(k)} << 1) >> (16 - TF);
    t = (t + 18'd1) >> 1;
    return TW'(signed'(t));
  endfunction

  function automatic logic signed [TW-1:0] sine_deg(input logic [8:0] a);
    logic signed [TW-1:0] r;
    if (a <= 9'd90)       r = trig_entry(a[6:0]);
    else if (a <= 9'd180) r = trig_entry(7'(9'd180 - a));
    else if (a <= 9'd270) r = -trig_entry(7'(a - 9'd180));
    else                  r = -trig_entry(7'(9'd360 - a));
    return r;
  endfunction

  function automatic logic signed [RW-1:0] round_q(input logic signed [PW:0] v);
    logic signed [PW:0] b;
    b = v + (PW+1)'(1 << (TF - 1));
    return RW'(b >>> TF);
  endfunction

  logic [8:0] a_red, a_cos;
  always_comb begin
    a_red = (angle_in >= 9'd360) ? angle_in - 9'd360 : angle_in;
    a_cos = (a_red + 9'd90 >= 9'd360) ? a_red + 9'd90 - 9'd360 : a_red + 9'd90;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r  <= x_in;
    y1_r  <= y_in;
    z1_r  <= z_in;
    op1_r <= op_in;
    l1_r  <= last_in;
    s1_r  <= sine_deg(a_red);
    c1_r  <= sine_deg(a_cos);

    op2_r <= op1_r;
    l2_r  <= l1_r;
    x2_r  <= x1_r;
    y2_r  <= y1_r;
    z2_r  <= z1_r;
    pxc_r <= PW'(x1_r * c1_r);
    pxs_r <= PW'(x1_r * s1_r);
    pyc_r <= PW'(y1_r * c1_r);
    pys_r <= PW'(y1_r * s1_r);
    pzc_r <= PW'(z1_r * c1_r);
    pzs_r <= PW'(z1_r * s1_r);
  end

  logic signed [RW-1:0] rx_nxt, ry_nxt, rz_nxt;
  always_comb begin
    rx_nxt = RW'(x2_r);
    ry_nxt = RW'(y2_r);
    rz_nxt = RW'(z2_r);
    unique case (rapp_pkg::opcode_t'(op2_r))
      rapp_pkg::OP_ROT_X: begin
        ry_nxt = round_q((PW+1)'(pyc_r) - (PW+1)'(pzs_r));
        rz_nxt = round_q((PW+1)'(pys_r) + (PW+1)'(pzc_r));
      end
      rapp_pkg::OP_ROT_Y: begin
        rx_nxt = round_q((PW+1)'(pxc_r) + (PW+1)'(pzs_r));
        rz_nxt = round_q((PW+1)'(pzc_r) - (PW+1)'(pxs_r));
      end
      rapp_pkg::OP_ROT_Z: begin
        rx_nxt = round_q((PW+1)'(pxc_r) - (PW+1)'(pys_r));
        ry_nxt = round_q((PW+1)'(pxs_r) + (PW+1)'(pyc_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rx3_r <= rx_nxt;
    ry3_r <= ry_nxt;
    rz3_r <= rz_nxt;
    l3_r  <= l2_r;
  end

  assign out_valid = v3_r;
  assign rx_out    = rx3_r;
  assign ry_out    = ry3_r;
  assign rz_out    = rz3_r;
  assign last_out  = l3_r;
endmodule

>>> rtl/core/rapp_fifo.sv
// Short queue between the rotation front end and the projection back end.
module rapp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = rapp_pkg::FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         not_empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assign rd_data   = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
endmodule

>>> rtl/core/rapp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rapp_div #(
  parameter int NW = 48,
  parameter int DW = 26,
  parameter int TW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] num_in,
  input  logic [DW-1:0] den_in,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [NW-1:0] quo_out,
  output logic [TW-1:0] tag_out
);
  logic          v_r   [NW+1];
  logic [NW-1:0] n_r   [NW+1];
  logic [NW-1:0] q_r   [NW+1];
  logic [DW:0]   rem_r [NW+1];
  logic [DW-1:0] d_r   [NW+1];
  logic [TW-1:0] t_r   [NW+1];

  always_comb begin
    v_r[0]   = in_valid;
    n_r[0]   = num_in;
    q_r[0]   = '0;
    rem_r[0] = '0;
    d_r[0]   = den_in;
    t_r[0]   = tag_in;
  end

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW+1:0] trial;
    logic          ge;
    assign trial = {rem_r[i], n_r[i][NW-1-i]};
    assign ge    = (trial >= {2'b00, d_r[i]});
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else        v_r[i+1] <= v_r[i];
    end
    always_ff @(posedge clk) begin
      n_r[i+1]   <= n_r[i];
      d_r[i+1]   <= d_r[i];
      t_r[i+1]   <= t_r[i];
      rem_r[i+1] <= ge ? (DW+1)'(trial - {2'b00, d_r[i]}) : (DW+1)'(trial);
      q_r[i+1]   <= {q_r[i][NW-2:0], ge};
    end
  end

  assign out_valid = v_r[NW];
  assign quo_out   = q_r[NW];
  assign tag_out   = t_r[NW];
endmodule

>>> rtl/core/rapp_back.sv
// Back end: projection by division, saturation and status.
module rapp_back #(
  parameter int CW = rapp_pkg::COORD_WIDTH_DEF,
  parameter int RW = CW + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [RW-1:0] rx_in,
  input  logic signed [RW-1:0] ry_in,
  input  logic signed [RW-1:0] rz_in,
  input  logic                 last_in,
  input  logic [rapp_pkg::DIST_WIDTH-1:0] view_dist,
  output logic                 out_valid,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic [1:0]           status,
  output logic                 last_out
);
  localparam int DEN_W = RW + 2;
  localparam int NW    = rapp_pkg::DIST_WIDTH + RW;
  localparam int TAGW  = 4;

  // Stage A: denominator and products.
  logic                    va_r, za_r, la_r, nx_r, ny_r, dn_r;
  logic [NW-1:0]           mx_r, my_r;
  logic [DEN_W-1:0]        dm_r;
  logic signed [DEN_W-1:0] den;
  logic signed [NW:0]      px, py;

  always_comb begin
    den = DEN_W'(signed'({1'b0, view_dist})) - DEN_W'(rz_in);
    px  = (NW+1)'(signed'({1'b0, view_dist})) * (NW+1)'(rx_in);
    py  = (NW+1)'(signed'({1'b0, view_dist})) * (NW+1)'(ry_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    za_r <= (den == '0);
    la_r <= last_in;
    nx_r <= px[NW];
    ny_r <= py[NW];
    dn_r <= den[DEN_W-1];
    mx_r <= px[NW] ? NW'(-px) : NW'(px);
    my_r <= py[NW] ? NW'(-py) : NW'(py);
    dm_r <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  end

  logic [TAGW-1:0] tag_a, tag_x;
  logic [TAGW-1:0] tag_y;
  logic            vx, vy;
  logic [NW-1:0]   qx, qy;
  assign tag_a = {la_r, za_r, nx_r ^ dn_r, ny_r ^ dn_r};

  rapp_div #(.NW(NW), .DW(DEN_W), .TW(TAGW)) u_div_x (
    .clk, .rst_n, .in_valid(va_r), .num_in(mx_r), .den_in(dm_r), .tag_in(tag_a),
    .out_valid(vx), .quo_out(qx), .tag_out(tag_x)
  );
  rapp_div #(.NW(NW), .DW(DEN_W), .TW(TAGW)) u_div_y (
    .clk, .rst_n, .in_valid(va_r), .num_in(my_r), .den_in(dm_r), .tag_in(tag_a),
    .out_valid(vy), .quo_out(qy), .tag_out(tag_y)
  );

  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] xs, ys;
  logic                 satx, saty;
  always_comb begin
    // Magnitude limit: positive up to MAX, negative up to MAX+1.
    if (tag_x[1]) begin
      satx = (qx > NW'(MAXV) + NW'(1));
      xs   = satx ? MINV : CW'(-qx);
    end else begin
      satx = (qx > NW'(MAXV));
      xs   = satx ? MAXV : CW'(qx);
    end
    if (tag_x[0]) begin
      saty = (qy > NW'(MAXV) + NW'(1));
      ys   = saty ? MINV : CW'(-qy);
    end else begin
      saty = (qy > NW'(MAXV));
      ys   = saty ? MAXV : CW'(qy);
    end
  end

  logic                 vo_r, lo_r;
  logic signed [CW-1:0] xo_r, yo_r;
  logic [1:0]           so_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else        vo_r <= vx & vy;
  end
  always_ff @(posedge clk) begin
    lo_r <= tag_x[3] & tag_y[3];
    if (tag_x[2]) begin
      xo_r <= '0;
      yo_r <= '0;
      so_r <= rapp_pkg::ST_ZERO;
    end else begin
      xo_r <= xs;
      yo_r <= ys;
      so_r <= (satx | saty) ? rapp_pkg::ST_SAT : rapp_pkg::ST_OK;
    end
  end

  assign out_valid = vo_r;
  assign x_out     = xo_r;
  assign y_out     = yo_r;
  assign status    = so_r;
  assign last_out  = lo_r;
endmodule

>>> rtl/core/rotate_and_perspective_project_core.sv
// Top level of the rotate and perspective projection core.
// Each transaction passes through the front end, the queue and then the back end.
// Throughput: one transaction per clock; the long pipelined divider sets the latency.
// busy is never raised, since nothing downstream can stall and every stage advances.
// Reset (rst_n low, synchronous) empties every stage and restores view distance 30.0.
// The receiver cannot stall: each result appears for one cycle with out_valid.
module rotate_and_perspective_project_core #(
  parameter int COORD_WIDTH    = rapp_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = rapp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_x_in,
  input  logic signed [COORD_WIDTH-1:0] in_y_in,
  input  logic signed [COORD_WIDTH-1:0] in_z_in,
  input  logic [1:0]                    in_opcode,
  input  logic [8:0]                    in_angle_deg,
  input  logic                          in_last_point,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_x_out,
  output logic signed [COORD_WIDTH-1:0] out_y_out,
  output logic [1:0]                    out_status,
  output logic                          out_last_point_out,
  input  logic                          cfg_we,
  input  logic [rapp_pkg::DIST_WIDTH-1:0] cfg_wdata
);
  // Rotated coordinates carry two guard bits of growth.
  localparam int RW = COORD_WIDTH + 2;
  localparam int QW = 3 * RW + 1;

  logic [rapp_pkg::DIST_WIDTH-1:0] dist_r;
  always_ff @(posedge clk) begin
    if (!rst_n)      dist_r <= rapp_pkg::DIST_RESET;
    else if (cfg_we) dist_r <= cfg_wdata;
  end

  // The pipeline never stalls, so every start transaction is taken.
  assign busy = 1'b0;

  logic          fv, fl;
  logic signed [RW-1:0] frx, fry, frz;
  rapp_front #(.CW(COORD_WIDTH), .TF(TRIG_FRAC_BITS), .RW(RW)) u_front (
    .clk, .rst_n, .in_valid(start & ~busy),
    .x_in(in_x_in), .y_in(in_y_in), .z_in(in_z_in),
    .op_in(in_opcode), .angle_in(in_angle_deg), .last_in(in_last_point),
    .out_valid(fv), .rx_out(frx), .ry_out(fry), .rz_out(frz), .last_out(fl)
  );

  // The queue decouples the two halves; the back end drains one entry per cycle while the queue is not empty.
  logic [QW-1:0] q_rd;
  logic          q_ne;
  rapp_fifo #(.W(QW), .DEPTH(rapp_pkg::FIFO_DEPTH)) u_fifo (
    .clk, .rst_n, .wr_en(fv), .wr_data({fl, frx, fry, frz}),
    .rd_en(q_ne), .rd_data(q_rd), .not_empty(q_ne)
  );

  rapp_back #(.CW(COORD_WIDTH), .RW(RW)) u_back (
    .clk, .rst_n, .in_valid(q_ne),
    .rx_in(q_rd[3*RW-1:2*RW]), .ry_in(q_rd[2*RW-1:RW]), .rz_in(q_rd[RW-1:0]),
    .last_in(q_rd[QW-1]), .view_dist(dist_r),
    .out_valid(out_valid), .x_out(out_x_out), .y_out(out_y_out),
    .status(out_status), .last_out(out_last_point_out)
  );
endmodule

>>> rtl/core/rapp_checker.sv
// Port-level checker for the rotate and projection core, with its bind.
module rapp_checker #(
  parameter int COORD_WIDTH = rapp_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   busy,
  input logic                   out_valid,
  input logic [COORD_WIDTH-1:0] out_x_out,
  input logic [COORD_WIDTH-1:0] out_y_out,
  input logic [1:0]             out_status
);
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == rapp_pkg::ST_OK || out_status == rapp_pkg::ST_SAT ||
                   out_status == rapp_pkg::ST_ZERO))
    else $error("illegal status code");
  a_zero_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == rapp_pkg::ST_ZERO) |-> (out_x_out == '0 && out_y_out == '0))
    else $error("zero denominator result not zero");
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind rotate_and_perspective_project_core rapp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chk (
  .clk, .rst_n, .busy, .out_valid, .out_x_out, .out_y_out, .out_status
);
